// ----- src/isr_pkg.sv -----
package isr_pkg;

  // Port widths, fixed by the interface
  localparam int RADICAND_W = 64;
  localparam int ROOT_W     = 33;

endpackage

// ----- src/integer_sqrt_rounded.sv -----
// Rounded integer square root of an unsigned radicand.
//
// Request channel: drive in_radicand and raise start; the request is taken
// at the rising edge where start is high and busy is low. Only the low
// IN_WIDTH bits of in_radicand are used.
// Result channel: out_root is valid for exactly one cycle, flagged by
// out_valid. There is no back-pressure; the receiver must take it then.
//
// Datapath: a row of restoring digit cells, one per bit of the unrounded
// root, each with a fixed power-of-four probe. A request enters the first
// cell and walks down the row one cell per cycle; a final stage rounds up
// when the remainder exceeds the partial root and registers the result.
// The row holds NCELL = ((IN_WIDTH-1)/2) + 1 cells (32 for IN_WIDTH = 64).
// Only one request is in the row at a time: busy stays high while a
// request is in the row and drops as the result is registered, so the
// next request can be taken in the cycle the result is shown.
// Reset: synchronous, active low; clears every valid flag and busy. No
// state is kept between requests.
module integer_sqrt_rounded #(
  parameter int IN_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [isr_pkg::RADICAND_W-1:0] in_radicand,
  output logic                          out_valid,
  output logic [isr_pkg::ROOT_W-1:0]     out_root
);
  import isr_pkg::*;

  localparam int W     = IN_WIDTH;
  // top probe exponent: highest even value below IN_WIDTH
  localparam int TOP_E = ((IN_WIDTH - 1) / 2) * 2;
  localparam int NCELL = TOP_E / 2 + 1;

  logic         accept;
  logic         busy_r;
  logic         busy_nxt;

  // links between neighbouring cells; link 0 feeds the first cell
  logic         vld_c [NCELL+1];
  logic [W-1:0] rem_c [NCELL+1];
  logic [W:0]   acc_c [NCELL+1];

  assign accept = start && !busy_r;

  // first cell sees the masked radicand and an empty root
  assign vld_c[0] = accept;
  assign rem_c[0] = in_radicand[W-1:0];
  assign acc_c[0] = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    isr_cell #(
      .W         (W),
      .PROBE_EXP (TOP_E - 2 * i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (vld_c[i]),
      .in_rem  (rem_c[i]),
      .in_acc  (acc_c[i]),
      .out_vld (vld_c[i+1]),
      .out_rem (rem_c[i+1]),
      .out_acc (acc_c[i+1])
    );
  end

  isr_round #(
    .W (W)
  ) u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (vld_c[NCELL]),
    .in_rem    (rem_c[NCELL]),
    .in_acc    (acc_c[NCELL]),
    .out_valid (out_valid),
    .out_root  (out_root)
  );

  // busy from acceptance until the last cell hands over to the rounding stage
  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (vld_c[NCELL]) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

// ----- src/isr_cell.sv -----
module isr_cell #(
  parameter int W         = 64,
  parameter int PROBE_EXP = 62
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_vld,
  input  logic [W-1:0] in_rem,
  input  logic [W:0]   in_acc,
  output logic         out_vld,
  output logic [W-1:0] out_rem,
  output logic [W:0]   out_acc
);

  localparam logic [W:0] PROBE  = {{W{1'b0}}, 1'b1} << PROBE_EXP;
  localparam logic [W:0] PROBE2 = PROBE << 1;

  logic         vld_r;
  logic [W-1:0] rem_r;
  logic [W:0]   acc_r;
  logic [W:0]   trial;
  logic         fits;
  logic [W-1:0] rem_nxt;
  logic [W:0]   acc_nxt;

  // one restoring step: try to take off (acc + probe)
  always_comb begin
    trial = in_acc + PROBE;
    fits  = {1'b0, in_rem} >= trial;
    if (fits) begin
      rem_nxt = in_rem - trial[W-1:0];
      acc_nxt = (in_acc + PROBE2) >> 1;
    end else begin
      rem_nxt = in_rem;
      acc_nxt = in_acc >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_rem = rem_r;
  assign out_acc = acc_r;

endmodule

// ----- src/isr_round.sv -----
module isr_round #(
  parameter int W = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic [W-1:0]              in_rem,
  input  logic [W:0]                in_acc,
  output logic                      out_valid,
  output logic [isr_pkg::ROOT_W-1:0] out_root
);
  import isr_pkg::*;

  logic              valid_r;
  logic [ROOT_W-1:0] root_r;
  logic [W:0]        root_nxt;

  // round up when remainder exceeds the partial root
  always_comb begin
    root_nxt = in_acc;
    if ({1'b0, in_rem} > in_acc) begin
      root_nxt = in_acc + {{W{1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      root_r <= ROOT_W'(root_nxt);
    end
  end

  assign out_valid = valid_r;
  assign out_root  = root_r;

endmodule
